// File: rtl/dlar_pkg.sv
package dlar_pkg;

    localparam int MAP_ENTRIES = 64;
    localparam int MAP_IDX_W   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int MAP_CNT_W   = $clog2(MAP_ENTRIES + 1);

    localparam int OFS_W     = 24;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [7:0] OP_VTX     = 8'h04;
    localparam logic [7:0] OP_COL     = 8'h07;
    localparam logic [7:0] OP_MOVEWORD = 8'hbc;
    localparam logic [7:0] OP_SETTIMG = 8'hfd;
    localparam logic [7:0] OP_ENDDL   = 8'hb8;
    localparam logic [7:0] OP_SEG_01  = 8'h01;
    localparam logic [7:0] OP_SEG_03  = 8'h03;
    localparam logic [7:0] OP_SEG_06  = 8'h06;
    localparam logic [7:0] OP_SEG_FE  = 8'hfe;
    localparam logic [7:0] OP_SEG_FF  = 8'hff;
    localparam logic [3:0] SEG_RELOC  = 4'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BASE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_SEG  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RELOCATE  = CFG_IDX_W'(3);

    typedef struct packed {
        logic [OFS_W-1:0] src_base;
        logic [OFS_W-1:0] dst_base;
        logic             mark_segmented;
        logic             relocate;
    } t_cfg;

    typedef struct packed {
        logic lookup;
        logic arith;
        logic mark;
        logic eol;
    } t_cls;

    typedef struct packed {
        logic             is_cmd;
        logic [31:0]      hi;
        logic [31:0]      lo;
        logic [OFS_W-1:0] tex_src;
        logic [OFS_W-1:0] tex_dst;
        t_cls             cls;
    } t_qent;

    typedef struct packed {
        logic [OFS_W-1:0] src;
        logic [OFS_W-1:0] dst;
    } t_map_ent;

    typedef struct packed {
        logic [31:0] word_hi;
        logic [31:0] word_lo;
        logic        end_of_list;
        logic        range_error;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/dlar_if.sv
interface dlar_in_if;
    import dlar_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [63:0]      command_word;
    logic [OFS_W-1:0] tex_source;
    logic [OFS_W-1:0] tex_dest;

    modport source (output valid, command, command_word, tex_source, tex_dest, input ready);
    modport sink   (input valid, command, command_word, tex_source, tex_dest, output ready);
endinterface

interface dlar_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_hi;
    logic [31:0] word_lo;
    logic        end_of_list;
    logic        range_error;

    modport source (output valid, word_hi, word_lo, end_of_list, range_error, input ready);
    modport sink   (input valid, word_hi, word_lo, end_of_list, range_error, output ready);
endinterface

interface dlar_cfg_if;
    import dlar_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dlar_front.sv
module dlar_front import dlar_pkg::*; (
    dlar_in_if.sink i_in,
    input  t_cfg    i_cfg,
    input  logic    i_q_full,
    output logic    o_push,
    output t_qent   o_ent
);

    logic [7:0] op;
    logic [3:0] seg;
    logic       has_addr;
    logic       is_seg;
    logic       reloc;

    assign op  = i_in.command_word[63:56];
    assign seg = i_in.command_word[27:24];

    assign has_addr = (op == OP_VTX) || (op == OP_COL) || (op == OP_MOVEWORD)
                   || (op == OP_SETTIMG);
    assign is_seg   = (op == OP_SEG_01) || (op == OP_SEG_03) || (op == OP_VTX)
                   || (op == OP_SEG_06) || (op == OP_COL) || (op == OP_SETTIMG)
                   || (op == OP_SEG_FE) || (op == OP_SEG_FF);
    assign reloc    = i_cfg.relocate && has_addr && (seg == SEG_RELOC);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_ent.is_cmd     = i_in.command;
        o_ent.hi         = i_in.command_word[63:32];
        o_ent.lo         = i_in.command_word[31:0];
        o_ent.tex_src    = i_in.tex_source;
        o_ent.tex_dst    = i_in.tex_dest;
        o_ent.cls.lookup = reloc && (op == OP_SETTIMG);
        o_ent.cls.arith  = reloc && (op != OP_SETTIMG);
        o_ent.cls.mark   = i_cfg.mark_segmented && is_seg;
        o_ent.cls.eol    = (op == OP_ENDDL);
    end

endmodule

// File: rtl/dlar_queue.sv
module dlar_queue import dlar_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_ent
);

    t_qent              r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/dlar_back.sv
module dlar_back import dlar_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_qent i_q_ent,
    output logic  o_pop,
    dlar_out_if.source o_res
);

    t_state               r_state;
    t_state               n_state;
    t_map_ent             r_mem [MAP_ENTRIES];
    t_map_ent             r_rd;
    logic [MAP_CNT_W-1:0] r_count;
    logic [MAP_CNT_W-1:0] r_idx;
    logic [MAP_CNT_W-1:0] idx_inc;
    t_qent                r_cur;
    logic [OFS_W-1:0]     r_tex_ofs;
    logic                 r_out_valid;
    t_res                 r_out;

    logic                 out_free;
    logic                 wr_en;
    logic [MAP_IDX_W-1:0] rd_addr;
    logic                 load;
    t_res                 res;
    logic                 start_scan;
    logic                 scan_miss;
    logic                 scan_hit;
    logic [OFS_W-1:0]     ofs;
    logic [OFS_W-1:0]     ofs_new;
    logic [31:0]          lo_arith;

    assign out_free  = !r_out_valid || o_res.ready;
    assign idx_inc   = r_idx + 1'b1;
    assign scan_miss = (r_idx >= r_count);
    assign scan_hit  = !scan_miss && (r_rd.src == r_cur.lo[OFS_W-1:0]);

    assign ofs      = i_q_ent.lo[OFS_W-1:0];
    assign ofs_new  = ofs - i_cfg.src_base + i_cfg.dst_base;
    assign lo_arith = i_q_ent.cls.arith ? {i_q_ent.lo[31:OFS_W], ofs_new} : i_q_ent.lo;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_ent.is_cmd && i_q_ent.cls.lookup) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_miss || scan_hit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = '0;
        load       = 1'b0;
        start_scan = 1'b0;
        res        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (!i_q_ent.is_cmd) begin
                        o_pop = 1'b1;
                        wr_en = (r_count < MAP_CNT_W'(MAP_ENTRIES));
                    end else if (i_q_ent.cls.lookup) begin
                        o_pop      = 1'b1;
                        start_scan = 1'b1;
                    end else if (out_free) begin
                        o_pop = 1'b1;
                        load  = 1'b1;
                    end
                end
                res.word_hi     = i_q_ent.hi;
                res.word_lo     = {lo_arith[31:1], lo_arith[0] | i_q_ent.cls.mark};
                res.end_of_list = i_q_ent.cls.eol;
                res.range_error = i_q_ent.cls.arith && (ofs < i_cfg.src_base);
            end
            ST_SCAN: begin
                rd_addr = idx_inc[MAP_IDX_W-1:0];
            end
            ST_EMIT: begin
                load            = out_free;
                res.word_hi     = r_cur.hi;
                res.word_lo     = {r_cur.lo[31:OFS_W], r_tex_ofs[OFS_W-1:1],
                                   r_tex_ofs[0] | r_cur.cls.mark};
                res.end_of_list = r_cur.cls.eol;
                res.range_error = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[MAP_IDX_W-1:0]] <= '{src: i_q_ent.tex_src, dst: i_q_ent.tex_dst};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (start_scan) begin
            r_cur <= i_q_ent;
        end
        if (r_state == ST_SCAN) begin
            r_tex_ofs <= scan_hit ? r_rd.dst : '0;
        end
        if (load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (start_scan) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= idx_inc;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.word_hi     = r_out.word_hi;
    assign o_res.word_lo     = r_out.word_lo;
    assign o_res.end_of_list = r_out.end_of_list;
    assign o_res.range_error = r_out.range_error;

endmodule

// File: rtl/display_list_address_relocator.sv
// A command word enters the queue, then the output register once it is free. Throughput:
// 1 beat per cycle for inserts, and for all commands but relocated settimg while ready.
// A relocated settimg scans the mapping table one entry per cycle through its read port:
// it holds the back end while it scans up to the first match or to the last filled entry.
// Reset (synchronous, active low) empties the queue and the output register, zeroes the
// entry count and restores the register defaults; table contents stay undefined.
module display_list_address_relocator import dlar_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlar_in_if.sink     i_in,
    dlar_cfg_if.sink    i_cfg,
    dlar_out_if.source  o_res
);

    t_cfg  r_cfg;
    logic  push;
    t_qent push_ent;
    logic  q_full;
    logic  q_valid;
    t_qent q_ent;
    logic  pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_base       <= '0;
            r_cfg.dst_base       <= '0;
            r_cfg.mark_segmented <= 1'b1;
            r_cfg.relocate       <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SRC_BASE: r_cfg.src_base       <= i_cfg.data[OFS_W-1:0];
                CFG_DST_BASE: r_cfg.dst_base       <= i_cfg.data[OFS_W-1:0];
                CFG_MARK_SEG: r_cfg.mark_segmented <= i_cfg.data[0];
                CFG_RELOCATE: r_cfg.relocate       <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    dlar_front u_front (
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_ent    (push_ent)
    );

    dlar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    dlar_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

// File: rtl/dlar_chk.sv
module dlar_chk import dlar_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_word_hi,
    input logic [31:0] i_word_lo,
    input logic        i_end_of_list,
    input logic        i_range_error
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_word_hi)
            && $stable(i_word_lo) && $stable(i_end_of_list) && $stable(i_range_error))
        else $error("result beat changed while stalled");

    a_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end_of_list |-> i_word_hi[31:24] == OP_ENDDL)
        else $error("end of list on wrong opcode");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_range_error |->
            (i_word_hi[31:24] == OP_VTX || i_word_hi[31:24] == OP_COL
             || i_word_hi[31:24] == OP_MOVEWORD) && i_word_lo[27:24] == SEG_RELOC)
        else $error("range error on a word that is not relocated");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind display_list_address_relocator dlar_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_word_hi     (o_res.word_hi),
    .i_word_lo     (o_res.word_lo),
    .i_end_of_list (o_res.end_of_list),
    .i_range_error (o_res.range_error)
);

// File: tb/tb.sv
module tb;
    import dlar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_MAP_INSERT = 1'b0;
    localparam logic CMD_WORD       = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(8'ha5);

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TICKS = 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic             command;
        logic [63:0]      word;
        logic [OFS_W-1:0] tex_src;
        logic [OFS_W-1:0] tex_dst;
    } dl_item_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic i_clk;
    logic i_rst_n;

    dlar_in_if  in_if ();
    dlar_cfg_if cfg_if ();
    dlar_out_if res_if ();

    display_list_address_relocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // predictor state
    logic [OFS_W-1:0] m_src_base;
    logic [OFS_W-1:0] m_dst_base;
    logic             m_mark;
    logic             m_reloc;
    logic [OFS_W-1:0] m_map_src [MAP_ENTRIES];
    logic [OFS_W-1:0] m_map_dst [MAP_ENTRIES];
    int               m_map_count;

    dl_item_t         stim_q [$];
    t_res             words_due [$];
    logic [OFS_W-1:0] known_src [$];

    int       n_err;
    int       quiet_cycles;
    bit       in_beat;
    bit       no_gaps;
    int       burst_left;
    int       gap_left;
    int       hold_reqs;
    int       hold_taken;
    int       hold_left;
    rx_mode_t rx_mode;
    int       rx_left;
    logic     rx_tick;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic is_segmented(logic [7:0] op);
        return op == OP_SEG_01 || op == OP_SEG_03 || op == OP_VTX || op == OP_SEG_06 ||
               op == OP_COL || op == OP_SETTIMG || op == OP_SEG_FE || op == OP_SEG_FF;
    endfunction

    function automatic logic carries_addr(logic [7:0] op);
        return op == OP_VTX || op == OP_COL || op == OP_MOVEWORD || op == OP_SETTIMG;
    endfunction

    function automatic t_res relocate_word(logic [63:0] w);
        t_res             r;
        logic [7:0]       op;
        logic [31:0]      lo;
        logic [OFS_W-1:0] ofs;
        logic             err;
        logic             found;
        op    = w[63:56];
        lo    = w[31:0];
        err   = 1'b0;
        found = 1'b0;
        if (m_reloc && carries_addr(op) && lo[27:24] == SEG_RELOC) begin
            ofs = lo[OFS_W-1:0];
            if (op == OP_SETTIMG) begin
                for (int i = 0; i < m_map_count; i++) begin
                    if (!found && m_map_src[i] == lo[OFS_W-1:0]) begin
                        found = 1'b1;
                        ofs   = m_map_dst[i];
                    end
                end
                if (!found)
                    ofs = '0;
            end else begin
                err = ofs < m_src_base;
                ofs = ofs - m_src_base + m_dst_base;
            end
            lo = {lo[31:24], ofs};
        end
        if (m_mark && is_segmented(op))
            lo[0] = 1'b1;
        r.word_hi     = w[63:32];
        r.word_lo     = lo;
        r.end_of_list = op == OP_ENDDL;
        r.range_error = err;
        return r;
    endfunction

    function automatic dl_item_t map_item(logic [OFS_W-1:0] src, logic [OFS_W-1:0] dst);
        dl_item_t it;
        it.command = CMD_MAP_INSERT;
        it.word    = {$urandom, $urandom};
        it.tex_src = src;
        it.tex_dst = dst;
        known_src.push_back(src);
        return it;
    endfunction

    function automatic dl_item_t word_item(logic [63:0] w);
        dl_item_t it;
        it.command = CMD_WORD;
        it.word    = w;
        it.tex_src = OFS_W'($urandom);
        it.tex_dst = OFS_W'($urandom);
        return it;
    endfunction

    function automatic logic [63:0] dl_word(logic [7:0] op, logic [3:0] seg,
                                            logic [OFS_W-1:0] ofs);
        return {op, 24'($urandom), 4'($urandom), seg, ofs};
    endfunction

    function automatic dl_item_t rand_item();
        logic [7:0]       hot_ops [10];
        logic [7:0]       op;
        logic [3:0]       seg;
        logic [OFS_W-1:0] ofs;
        logic [OFS_W-1:0] src;
        hot_ops = '{OP_VTX, OP_COL, OP_MOVEWORD, OP_SETTIMG, OP_ENDDL,
                    OP_SEG_01, OP_SEG_03, OP_SEG_06, OP_SEG_FE, OP_SEG_FF};
        if ($urandom_range(0, 99) < 12) begin
            if (known_src.size() != 0 && $urandom_range(0, 3) == 0)
                src = known_src[$urandom_range(0, known_src.size() - 1)];
            else
                src = OFS_W'($urandom);
            return map_item(src, OFS_W'($urandom));
        end
        op  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : hot_ops[$urandom_range(0, 9)];
        seg = ($urandom_range(0, 9) < 7) ? SEG_RELOC : 4'($urandom);
        if (op == OP_SETTIMG && known_src.size() != 0 && $urandom_range(0, 9) < 7) begin
            ofs = known_src[$urandom_range(0, known_src.size() - 1)];
        end else begin
            case ($urandom_range(0, 5))
                0: ofs = m_src_base + OFS_W'($urandom_range(0, 255));
                1: ofs = m_src_base - OFS_W'($urandom_range(1, 255));
                2: ofs = m_src_base;
                3: ofs = '0;
                4: ofs = '1;
                default: ofs = OFS_W'($urandom);
            endcase
        end
        return word_item(dl_word(op, seg, ofs));
    endfunction

    task automatic report_mismatch(string what, t_res want, t_res got);
        n_err++;
        if (n_err <= MAX_REPORTS)
            $display("mismatch (%s): expected hi=%h lo=%h eol=%b rerr=%b, got hi=%h lo=%h eol=%b rerr=%b",
                     what, want.word_hi, want.word_lo, want.end_of_list, want.range_error,
                     got.word_hi, got.word_lo, got.end_of_list, got.range_error);
    endtask

    // monitor, predictor update and watchdog
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        bit   moved;
        in_beat = 1'b0;
        moved   = 1'b0;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                moved           = 1'b1;
                got.word_hi     = res_if.word_hi;
                got.word_lo     = res_if.word_lo;
                got.end_of_list = res_if.end_of_list;
                got.range_error = res_if.range_error;
                if (words_due.size() == 0) begin
                    want = '0;
                    report_mismatch("no beat pending", want, got);
                end else begin
                    want = words_due.pop_front();
                    if (got.word_hi !== want.word_hi || got.word_lo !== want.word_lo ||
                        got.end_of_list !== want.end_of_list ||
                        got.range_error !== want.range_error)
                        report_mismatch("field", want, got);
                end
            end
            if (in_if.valid && in_if.ready) begin
                moved   = 1'b1;
                in_beat = 1'b1;
                if (in_if.command == CMD_WORD) begin
                    words_due.push_back(relocate_word(in_if.command_word));
                end else if (m_map_count < MAP_ENTRIES) begin
                    m_map_src[m_map_count] = in_if.tex_source;
                    m_map_dst[m_map_count] = in_if.tex_dest;
                    m_map_count++;
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                case (cfg_if.index)
                    CFG_SRC_BASE: m_src_base = cfg_if.data[OFS_W-1:0];
                    CFG_DST_BASE: m_dst_base = cfg_if.data[OFS_W-1:0];
                    CFG_MARK_SEG: m_mark     = cfg_if.data[0];
                    CFG_RELOCATE: m_reloc    = cfg_if.data[0];
                    default: ;
                endcase
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[display_list_address_relocator] ERROR");
                $finish;
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        dl_item_t it;
        if (i_rst_n && (!in_if.valid || in_beat)) begin
            if (gap_left != 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (stim_q.size() != 0) begin
                it = stim_q.pop_front();
                in_if.valid        <= 1'b1;
                in_if.command      <= it.command;
                in_if.command_word <= it.word;
                in_if.tex_source   <= it.tex_src;
                in_if.tex_dest     <= it.tex_dst;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    if (no_gaps || $urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // long hold-off of the receiver
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (hold_taken < hold_reqs) begin
            hold_taken++;
            hold_left = HOLD_CYCLES;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        rx_tick = ~rx_tick;
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   res_if.ready <= 1'b1;
                RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                default:   res_if.ready <= rx_tick;
            endcase
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (stim_q.size() != 0 || in_if.valid || words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_phase(logic [OFS_W-1:0] src, logic [OFS_W-1:0] dst,
                             logic mark, logic reloc);
        wait_drained();
        write_reg(CFG_SRC_BASE, CFG_DAT_W'(src));
        write_reg(CFG_DST_BASE, CFG_DAT_W'(dst));
        write_reg(CFG_MARK_SEG, CFG_DAT_W'(mark));
        write_reg(CFG_RELOCATE, CFG_DAT_W'(reloc));
    endtask

    task automatic push_random(int n);
        repeat (n) stim_q.push_back(rand_item());
    endtask

    initial begin
        n_err        = 0;
        quiet_cycles = 0;
        in_beat      = 1'b0;
        no_gaps      = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        hold_reqs    = 0;
        hold_taken   = 0;
        hold_left    = 0;
        rx_mode      = RX_FREE;
        rx_left      = 0;
        rx_tick      = 1'b0;
        m_src_base   = '0;
        m_dst_base   = '0;
        m_mark       = 1'b1;
        m_reloc      = 1'b1;
        m_map_count  = 0;

        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.command      = CMD_WORD;
        in_if.command_word = '0;
        in_if.tex_source   = '0;
        in_if.tex_dest     = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_phase(24'h001000, 24'h400000, 1'b1, 1'b1);
        write_reg(CFG_UNUSED, $urandom);

        stim_q.push_back(map_item(24'h005000, 24'h00a000));
        stim_q.push_back(map_item(24'h005100, 24'hffffff));
        stim_q.push_back(map_item(24'h005000, 24'h123456));
        stim_q.push_back(map_item(24'hffffff, 24'h000000));
        stim_q.push_back(map_item(24'h000000, 24'h000001));
        stim_q.push_back(word_item(dl_word(OP_SETTIMG, SEG_RELOC, 24'h005000)));
        stim_q.push_back(word_item(dl_word(OP_SETTIMG, SEG_RELOC, 24'hffffff)));
        stim_q.push_back(word_item(dl_word(OP_SETTIMG, SEG_RELOC, 24'h000000)));
        stim_q.push_back(word_item(dl_word(OP_SETTIMG, SEG_RELOC, 24'h777777)));
        stim_q.push_back(word_item(dl_word(OP_SETTIMG, 4'd3, 24'h005000)));
        stim_q.push_back(word_item(dl_word(OP_VTX, SEG_RELOC, 24'h001000)));
        stim_q.push_back(word_item(dl_word(OP_VTX, SEG_RELOC, 24'h000fff)));
        stim_q.push_back(word_item(dl_word(OP_COL, SEG_RELOC, 24'hffffff)));
        stim_q.push_back(word_item(dl_word(OP_MOVEWORD, SEG_RELOC, 24'h000000)));
        stim_q.push_back(word_item(dl_word(OP_MOVEWORD, 4'd4, 24'h002345)));
        stim_q.push_back(word_item({OP_ENDDL, 56'h0}));
        stim_q.push_back(word_item(dl_word(OP_SEG_01, 4'($urandom), 24'($urandom))));
        stim_q.push_back(word_item(dl_word(OP_SEG_03, 4'($urandom), 24'($urandom))));
        stim_q.push_back(word_item(dl_word(OP_SEG_06, 4'($urandom), 24'($urandom))));
        stim_q.push_back(word_item(dl_word(OP_SEG_FE, 4'($urandom), 24'($urandom))));
        stim_q.push_back(word_item(dl_word(OP_SEG_FF, 4'($urandom), 24'($urandom))));
        stim_q.push_back(word_item('1));
        stim_q.push_back(word_item('0));
        stim_q.push_back(map_item(24'h00abcd, 24'h00dcba));
        stim_q.push_back(word_item(dl_word(OP_SETTIMG, SEG_RELOC, 24'h00abcd)));

        // hold the receiver off while the sender keeps pushing
        set_phase(24'h000100, 24'h800000, 1'b1, 1'b1);
        no_gaps = 1'b1;
        hold_reqs++;
        push_random(250);
        wait_drained();
        no_gaps = 1'b0;

        set_phase(24'hffffff, 24'h000000, 1'b1, 1'b1);
        push_random(200);
        set_phase(24'h000000, 24'hffffff, 1'b0, 1'b1);
        push_random(200);
        set_phase(24'($urandom), 24'($urandom), 1'b0, 1'b0);
        push_random(200);
        set_phase(24'($urandom), 24'($urandom), 1'b1, 1'b0);
        push_random(200);
        set_phase(24'($urandom), 24'($urandom), 1'b1, 1'b1);
        push_random(300);
        set_phase(24'h800000, 24'h7fffff, 1'b0, 1'b1);
        push_random(250);

        wait_drained();
        if (n_err == 0 && words_due.size() == 0)
            $display("[display_list_address_relocator] OK");
        else
            $display("[display_list_address_relocator] ERROR");
        $finish;
    end

endmodule
